// ===== rtl/apid_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the altitude PID / quad motor mixer.
// No dependencies; used by every module in rtl/.
package apid_pkg;

  // Fixed-point format and queue sizing defaults
  localparam int FRAC_BITS_DEFAULT   = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int CFG_INDEX_W         = 3;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Configuration register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ALT_SETPOINT    = 3'd0,
    REG_PROPORTIONAL    = 3'd1,
    REG_INTEGRAL        = 3'd2,
    REG_DERIVATIVE      = 3'd3,
    REG_ROLL_GAIN       = 3'd4,
    REG_PITCH_GAIN      = 3'd5,
    REG_HOVER_THRUST    = 3'd6,
    REG_MOTOR_LIMIT     = 3'd7
  } cfg_reg_t;

  // Configuration register file contents
  typedef struct packed {
    logic signed [31:0] alt_setpoint;
    logic signed [31:0] proportional_gain;
    logic signed [31:0] integral_gain_dt;
    logic signed [31:0] derivative_gain_per_dt;
    logic signed [31:0] roll_gain;
    logic signed [31:0] pitch_gain;
    logic signed [31:0] hover_thrust;
    logic        [30:0] motor_limit;
  } cfg_t;

  // One sensor sample
  typedef struct packed {
    logic signed [31:0] altitude;
    logic signed [31:0] roll_angle;
    logic signed [31:0] pitch_angle;
    logic signed [31:0] roll_rate;
    logic signed [31:0] pitch_rate;
  } sample_t;

  // One result: motor commands plus PID internals
  typedef struct packed {
    logic signed [31:0] motor_front_left;
    logic signed [31:0] motor_front_right;
    logic signed [31:0] motor_rear_left;
    logic signed [31:0] motor_rear_right;
    logic signed [31:0] alt_error;
    logic signed [31:0] integral_out;
    logic signed [31:0] error_difference;
    logic signed [31:0] vertical_command;
  } result_t;

  // Front-to-back queue entry: PID terms done, attitude inputs clamped
  typedef struct packed {
    logic signed [31:0] err;
    logic signed [31:0] sum;
    logic signed [31:0] diff;
    logic signed [31:0] roll_clamp;
    logic signed [31:0] pitch_clamp;
    logic signed [31:0] roll_rate;
    logic signed [31:0] pitch_rate;
  } qent_t;

  // Saturate a 33-bit signed value to 32 bits
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? S32_MIN : S32_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/apid_front.sv =====
`timescale 1ns / 1ps
// Front end: takes sensor samples, forms error, saturated integral and
// error difference, clamps attitude angles. Depends on apid_pkg.
module apid_front #(
  parameter int FRAC_BITS = apid_pkg::FRAC_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  apid_pkg::sample_t sample,
  input  apid_pkg::cfg_t   cfg,
  input  logic             q_full,
  output logic             push,
  output apid_pkg::qent_t  push_data
);

  localparam logic signed [31:0] ONE     = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] NEG_ONE = -ONE;

  // Capture stage
  logic               cap_valid;
  logic signed [31:0] cap_err;
  logic signed [31:0] cap_roll;
  logic signed [31:0] cap_pitch;
  logic signed [31:0] cap_roll_rate;
  logic signed [31:0] cap_pitch_rate;

  // Loop state
  logic signed [31:0] integral_sum;
  logic signed [31:0] previous_error;

  logic               accept;
  logic signed [31:0] err_next;
  logic signed [31:0] roll_next;
  logic signed [31:0] pitch_next;
  logic signed [31:0] sum_next;
  logic signed [31:0] diff_next;

  assign sample_stall = cap_valid && q_full;
  assign accept       = sample_valid && !sample_stall;
  assign push         = cap_valid && !q_full;

  // Error and attitude clamps on the incoming sample
  always_comb begin
    err_next = apid_pkg::sat33($signed({cfg.alt_setpoint[31], cfg.alt_setpoint})
                             - $signed({sample.altitude[31], sample.altitude}));
    if (sample.roll_angle > ONE) begin
      roll_next = ONE;
    end else if (sample.roll_angle < NEG_ONE) begin
      roll_next = NEG_ONE;
    end else begin
      roll_next = sample.roll_angle;
    end
    if (sample.pitch_angle > ONE) begin
      pitch_next = ONE;
    end else if (sample.pitch_angle < NEG_ONE) begin
      pitch_next = NEG_ONE;
    end else begin
      pitch_next = sample.pitch_angle;
    end
  end

  // Integral and difference against loop state
  always_comb begin
    sum_next  = apid_pkg::sat33($signed({integral_sum[31], integral_sum})
                              + $signed({cap_err[31], cap_err}));
    diff_next = apid_pkg::sat33($signed({cap_err[31], cap_err})
                              - $signed({previous_error[31], previous_error}));
    push_data.err         = cap_err;
    push_data.sum         = sum_next;
    push_data.diff        = diff_next;
    push_data.roll_clamp  = cap_roll;
    push_data.pitch_clamp = cap_pitch;
    push_data.roll_rate   = cap_roll_rate;
    push_data.pitch_rate  = cap_pitch_rate;
  end

  // Capture stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_valid <= 1'b0;
    end else if (accept) begin
      cap_valid <= 1'b1;
    end else if (push) begin
      cap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cap_err        <= err_next;
      cap_roll       <= roll_next;
      cap_pitch      <= pitch_next;
      cap_roll_rate  <= sample.roll_rate;
      cap_pitch_rate <= sample.pitch_rate;
    end
  end

  // Loop state advances once per transfer into the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum   <= '0;
      previous_error <= '0;
    end else if (push) begin
      integral_sum   <= sum_next;
      previous_error <= cap_err;
    end
  end

endmodule

// ===== rtl/apid_queue.sv =====
`timescale 1ns / 1ps
// Small FIFO between front end and back end.
// Depends on apid_pkg for the entry type.
module apid_queue #(
  parameter int DEPTH = apid_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  apid_pkg::qent_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output apid_pkg::qent_t head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  apid_pkg::qent_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/apid_back.sv =====
`timescale 1ns / 1ps
// Back end: gain multiplies, PID sum, motor mixing and clamping, result
// register. Depends on apid_pkg.
module apid_back #(
  parameter int FRAC_BITS = apid_pkg::FRAC_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  apid_pkg::cfg_t   cfg,
  input  logic             head_valid,
  input  apid_pkg::qent_t  head_data,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_stall,
  output apid_pkg::result_t result
);

  logic advance;

  // Stage 1: products
  logic               s1_valid;
  logic signed [63:0] s1_prod_p;
  logic signed [63:0] s1_prod_i;
  logic signed [63:0] s1_prod_d;
  logic signed [63:0] s1_prod_roll;
  logic signed [63:0] s1_prod_pitch;
  logic signed [31:0] s1_err;
  logic signed [31:0] s1_sum;
  logic signed [31:0] s1_diff;
  logic signed [31:0] s1_roll_rate;
  logic signed [31:0] s1_pitch_rate;

  // Stage 2: PID command and axis terms
  logic               s2_valid;
  logic signed [31:0] s2_cmd;
  logic signed [64:0] s2_roll_in;
  logic signed [64:0] s2_pitch_in;
  logic signed [31:0] s2_err;
  logic signed [31:0] s2_sum;
  logic signed [31:0] s2_diff;

  // Stage 3: thrust and axis sum/difference
  logic               s3_valid;
  logic signed [33:0] s3_thrust;
  logic signed [65:0] s3_rp;
  logic signed [65:0] s3_rm;
  logic signed [31:0] s3_cmd;
  logic signed [31:0] s3_err;
  logic signed [31:0] s3_sum;
  logic signed [31:0] s3_diff;

  logic signed [63:0] sh_p;
  logic signed [63:0] sh_i;
  logic signed [63:0] sh_d;
  logic signed [63:0] sh_roll;
  logic signed [63:0] sh_pitch;
  logic signed [65:0] pid_wide;
  logic signed [31:0] cmd_next;

  logic signed [66:0] lim_pos;
  logic signed [66:0] lim_neg;
  logic signed [66:0] mix_fl;
  logic signed [66:0] mix_fr;
  logic signed [66:0] mix_rl;
  logic signed [66:0] mix_rr;
  apid_pkg::result_t  result_next;

  // Whole pipe moves when the result register is free or being drained
  assign advance = !result_valid || !result_stall;
  assign pop     = head_valid && advance;

  // Floor shifts and saturated PID sum
  always_comb begin
    sh_p     = s1_prod_p >>> FRAC_BITS;
    sh_i     = s1_prod_i >>> FRAC_BITS;
    sh_d     = s1_prod_d >>> FRAC_BITS;
    sh_roll  = s1_prod_roll >>> FRAC_BITS;
    sh_pitch = s1_prod_pitch >>> FRAC_BITS;
    pid_wide = 66'(sh_p) + 66'(sh_i) + 66'(sh_d);
    if (pid_wide > 66'(apid_pkg::S32_MAX)) begin
      cmd_next = apid_pkg::S32_MAX;
    end else if (pid_wide < 66'(apid_pkg::S32_MIN)) begin
      cmd_next = apid_pkg::S32_MIN;
    end else begin
      cmd_next = pid_wide[31:0];
    end
  end

  // Mixer and symmetric clamp
  function automatic logic signed [31:0] clamp_lim(input logic signed [66:0] v,
                                                   input logic signed [66:0] hi,
                                                   input logic signed [66:0] lo);
    logic signed [66:0] r;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[31:0];
  endfunction

  always_comb begin
    lim_pos = $signed({36'd0, cfg.motor_limit});
    lim_neg = -lim_pos;
    mix_fl  = 67'(s3_thrust) - 67'(s3_rm);
    mix_fr  = 67'(s3_thrust) + 67'(s3_rp);
    mix_rl  = 67'(s3_thrust) - 67'(s3_rp);
    mix_rr  = 67'(s3_thrust) + 67'(s3_rm);
    result_next.motor_front_left  = clamp_lim(mix_fl, lim_pos, lim_neg);
    result_next.motor_front_right = clamp_lim(mix_fr, lim_pos, lim_neg);
    result_next.motor_rear_left   = clamp_lim(mix_rl, lim_pos, lim_neg);
    result_next.motor_rear_right  = clamp_lim(mix_rr, lim_pos, lim_neg);
    result_next.alt_error         = s3_err;
    result_next.integral_out      = s3_sum;
    result_next.error_difference  = s3_diff;
    result_next.vertical_command  = s3_cmd;
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= head_valid;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      result_valid <= s3_valid;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_prod_p     <= cfg.proportional_gain * head_data.err;
      s1_prod_i     <= cfg.integral_gain_dt * head_data.sum;
      s1_prod_d     <= cfg.derivative_gain_per_dt * head_data.diff;
      s1_prod_roll  <= cfg.roll_gain * head_data.roll_clamp;
      s1_prod_pitch <= cfg.pitch_gain * head_data.pitch_clamp;
      s1_err        <= head_data.err;
      s1_sum        <= head_data.sum;
      s1_diff       <= head_data.diff;
      s1_roll_rate  <= head_data.roll_rate;
      s1_pitch_rate <= head_data.pitch_rate;

      s2_cmd      <= cmd_next;
      s2_roll_in  <= 65'(sh_roll) + 65'(s1_roll_rate);
      s2_pitch_in <= 65'(sh_pitch) + 65'(s1_pitch_rate);
      s2_err      <= s1_err;
      s2_sum      <= s1_sum;
      s2_diff     <= s1_diff;

      s3_thrust <= 34'(cfg.hover_thrust) + 34'(s2_cmd);
      s3_rp     <= 66'(s2_roll_in) + 66'(s2_pitch_in);
      s3_rm     <= 66'(s2_roll_in) - 66'(s2_pitch_in);
      s3_cmd    <= s2_cmd;
      s3_err    <= s2_err;
      s3_sum    <= s2_sum;
      s3_diff   <= s2_diff;

      result <= result_next;
    end
  end

endmodule

// ===== rtl/altitude_pid_quad_motor_mixer_unit.sv =====
`timescale 1ns / 1ps
// Altitude PID with quad motor mixer, Q(31-F).F fixed point. Takes one sample
// per cycle while sample_stall is low and returns one result per sample, in
// order. The item passes six registers: the front-end capture (error, clamps,
// loaded at the transfer edge), the queue entry holding the saturated integral
// and difference, then four back-end stages (multiply, PID sum, thrust and axis
// terms, mix and clamp into the result register). The integral update is one
// add per cycle, so the sustained rate is one sample per clock while the result
// side does not stall. The queue of QUEUE_DEPTH entries lets the front end keep
// taking samples while the result side stalls, until the queue fills.
// Register writes are taken at any time (cfg_ready is always high) and must
// land while the block is idle.
// Depends on apid_pkg, apid_front, apid_queue and apid_back.
module altitude_pid_quad_motor_mixer_unit #(
  parameter int FRAC_BITS   = apid_pkg::FRAC_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = apid_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  apid_pkg::sample_t                sample,
  output logic                             result_valid,
  input  logic                             result_stall,
  output apid_pkg::result_t                result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [apid_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data
);

  apid_pkg::cfg_t  cfg;
  logic            q_full;
  logic            push;
  apid_pkg::qent_t push_data;
  logic            pop;
  logic            head_valid;
  apid_pkg::qent_t head_data;

  assign cfg_ready = 1'b1;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alt_setpoint           <= 32'sd1 <<< FRAC_BITS;
      cfg.proportional_gain      <= '0;
      cfg.integral_gain_dt       <= '0;
      cfg.derivative_gain_per_dt <= '0;
      cfg.roll_gain              <= '0;
      cfg.pitch_gain             <= '0;
      cfg.hover_thrust           <= '0;
      cfg.motor_limit            <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (apid_pkg::cfg_reg_t'(cfg_index))
        apid_pkg::REG_ALT_SETPOINT:    cfg.alt_setpoint           <= cfg_data;
        apid_pkg::REG_PROPORTIONAL:    cfg.proportional_gain      <= cfg_data;
        apid_pkg::REG_INTEGRAL:        cfg.integral_gain_dt       <= cfg_data;
        apid_pkg::REG_DERIVATIVE:      cfg.derivative_gain_per_dt <= cfg_data;
        apid_pkg::REG_ROLL_GAIN:       cfg.roll_gain              <= cfg_data;
        apid_pkg::REG_PITCH_GAIN:      cfg.pitch_gain             <= cfg_data;
        apid_pkg::REG_HOVER_THRUST:    cfg.hover_thrust           <= cfg_data;
        apid_pkg::REG_MOTOR_LIMIT:     cfg.motor_limit            <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  apid_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .cfg          (cfg),
    .q_full       (q_full),
    .push         (push),
    .push_data    (push_data)
  );

  apid_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  apid_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head_data    (head_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== dv/apid_result_check.sv =====
`timescale 1ns / 1ps
// Result checker for altitude_pid_quad_motor_mixer_unit. It watches the sample, config
// and result channels, predicts each result and compares results in order.
// Depends on apid_pkg.
module apid_result_check #(
  parameter int FRAC_BITS = apid_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  input  logic                             sample_stall,
  input  apid_pkg::sample_t                sample,
  input  logic                             result_valid,
  input  logic                             result_stall,
  input  apid_pkg::result_t                result,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [apid_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data,
  output int                               mismatches,
  output int                               awaited,
  output int                               checked
);

  // Shadow copy of the register file and the PID state
  apid_pkg::cfg_t     regs;
  logic signed [31:0] integral_acc;
  logic signed [31:0] last_error;
  apid_pkg::result_t  awaited_results[$];

  function automatic logic signed [31:0] clip32(input longint v);
    logic signed [31:0] r;
    if (v > longint'(apid_pkg::S32_MAX)) begin
      r = apid_pkg::S32_MAX;
    end else if (v < longint'(apid_pkg::S32_MIN)) begin
      r = apid_pkg::S32_MIN;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
    longint r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

  // Full 64-bit product, then an arithmetic shift (floor)
  function automatic longint q_mul(input logic signed [31:0] a, input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> FRAC_BITS;
  endfunction

  // Altitude PID plus quad mixer for one sample, from the current state
  function automatic apid_pkg::result_t predict_pid_mix(input apid_pkg::sample_t s);
    logic signed [31:0] tgt, hov, alt, ra, pa, rr, pr;
    logic signed [31:0] err, sum, diff, cmd;
    longint             one, rc, pc, roll_in, pitch_in, thrust, lim;
    apid_pkg::result_t  r;
    tgt = regs.alt_setpoint;
    hov = regs.hover_thrust;
    alt = s.altitude;
    ra  = s.roll_angle;
    pa  = s.pitch_angle;
    rr  = s.roll_rate;
    pr  = s.pitch_rate;
    one = longint'(1) <<< FRAC_BITS;

    err  = clip32(longint'(tgt) - longint'(alt));
    sum  = clip32(longint'(integral_acc) + longint'(err));
    diff = clip32(longint'(err) - longint'(last_error));
    cmd  = clip32(q_mul(regs.proportional_gain, err) + q_mul(regs.integral_gain_dt, sum) +
                  q_mul(regs.derivative_gain_per_dt, diff));

    // attitude angles limited to +-1.0 before the gain
    rc       = clamp_range(longint'(ra), -one, one);
    pc       = clamp_range(longint'(pa), -one, one);
    roll_in  = q_mul(regs.roll_gain, 32'(rc)) + longint'(rr);
    pitch_in = q_mul(regs.pitch_gain, 32'(pc)) + longint'(pr);
    thrust   = longint'(hov) + longint'(cmd);
    lim      = longint'({33'd0, regs.motor_limit});

    r.motor_front_left  = 32'(clamp_range(thrust - roll_in + pitch_in, -lim, lim));
    r.motor_front_right = 32'(clamp_range(thrust + roll_in + pitch_in, -lim, lim));
    r.motor_rear_left   = 32'(clamp_range(thrust - roll_in - pitch_in, -lim, lim));
    r.motor_rear_right  = 32'(clamp_range(thrust + roll_in - pitch_in, -lim, lim));
    r.alt_error         = err;
    r.integral_out      = sum;
    r.error_difference  = diff;
    r.vertical_command  = cmd;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Watch all three channels; every transfer is taken at the rising edge
  always @(posedge clk) begin : watch
    apid_pkg::result_t want;
    apid_pkg::result_t pred;
    if (rst) begin
      regs                 = '0;
      regs.alt_setpoint    = 32'(longint'(1) <<< FRAC_BITS);
      integral_acc         = '0;
      last_error           = '0;
      awaited_results.delete();
      mismatches           = 0;
      checked              = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          apid_pkg::REG_ALT_SETPOINT: regs.alt_setpoint           = cfg_data;
          apid_pkg::REG_PROPORTIONAL: regs.proportional_gain      = cfg_data;
          apid_pkg::REG_INTEGRAL:     regs.integral_gain_dt       = cfg_data;
          apid_pkg::REG_DERIVATIVE:   regs.derivative_gain_per_dt = cfg_data;
          apid_pkg::REG_ROLL_GAIN:    regs.roll_gain              = cfg_data;
          apid_pkg::REG_PITCH_GAIN:   regs.pitch_gain             = cfg_data;
          apid_pkg::REG_HOVER_THRUST: regs.hover_thrust           = cfg_data;
          apid_pkg::REG_MOTOR_LIMIT:  regs.motor_limit            = cfg_data[30:0];
          default: ;
        endcase
      end

      if (result_valid && !result_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no sample outstanding");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("motor_front_left", want.motor_front_left, result.motor_front_left);
          check_field("motor_front_right", want.motor_front_right, result.motor_front_right);
          check_field("motor_rear_left", want.motor_rear_left, result.motor_rear_left);
          check_field("motor_rear_right", want.motor_rear_right, result.motor_rear_right);
          check_field("alt_error", want.alt_error, result.alt_error);
          check_field("integral_out", want.integral_out, result.integral_out);
          check_field("error_difference", want.error_difference, result.error_difference);
          check_field("vertical_command", want.vertical_command, result.vertical_command);
          checked++;
        end
      end

      if (sample_valid && !sample_stall) begin
        pred         = predict_pid_mix(sample);
        integral_acc = pred.integral_out;
        last_error   = pred.alt_error;
        awaited_results.push_back(pred);
      end
    end
    awaited <= awaited_results.size();
  end

endmodule

// ===== dv/altitude_pid_quad_motor_mixer_unit_tb.sv =====
`timescale 1ns / 1ps
// Top of the altitude PID / motor mixer testbench: clock, reset, stimulus and verdict.
// Depends on apid_pkg, altitude_pid_quad_motor_mixer_unit and apid_result_check.
module altitude_pid_quad_motor_mixer_unit_tb;

  localparam int                 FB            = apid_pkg::FRAC_BITS_DEFAULT;
  localparam logic signed [31:0] ONE           = 32'sd1 <<< FB;
  localparam int                 RANDOM_PHASES = 10;
  localparam int                 PHASE_ITEMS   = 100;
  localparam int                 CYCLE_LIMIT   = 400000;

  typedef enum int {FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH} flow_mode_t;
  typedef enum int {CFG_MODERATE, CFG_MAX, CFG_MIN, CFG_MIXED} cfg_style_t;

  logic                             clk          = 1'b0;
  logic                             rst          = 1'b1;
  logic                             sample_valid = 1'b0;
  apid_pkg::sample_t                sample       = '0;
  logic                             result_stall = 1'b0;
  logic                             cfg_valid    = 1'b0;
  logic [apid_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [31:0]                      cfg_data     = '0;
  logic                             sample_stall;
  logic                             result_valid;
  logic                             cfg_ready;
  apid_pkg::result_t                result;

  int                 mismatches;
  int                 awaited;
  int                 checked;
  int                 cycles    = 0;
  int                 sent      = 0;
  int                 settings  = 0;
  int                 send_idle = 0;
  int                 stall_pct = 0;
  logic [31:0]        cfg_vals[8];
  logic signed [31:0] cur_target = ONE;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  altitude_pid_quad_motor_mixer_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  apid_result_check #(.FRAC_BITS(FB)) u_result_check (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .awaited      (awaited),
    .checked      (checked)
  );

  // Result side back-pressure
  always @(posedge clk) begin
    result_stall <= (stall_pct > 0) && (int'($urandom_range(99)) < stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic set_flow(input flow_mode_t mode);
    case (mode)
      FLOW_FREE:        begin send_idle = 0;  stall_pct = 0;  end
      FLOW_SEND_GAPS:   begin send_idle = 51; stall_pct = 0;  end
      FLOW_RECV_STALLS: begin send_idle = 0;  stall_pct = 51; end
      default:          begin send_idle = 7;  stall_pct = 7;  end
    endcase
  endtask

  // One sample transfer, with random idle cycles ahead of it
  task automatic send_sample(input apid_pkg::sample_t s);
    while (send_idle > 0 && int'($urandom_range(99)) < send_idle) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    sent++;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic settle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  // Write all eight registers from cfg_vals, back to back
  task automatic load_config();
    apid_pkg::cfg_reg_t r;
    r = r.first();
    do begin
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data  <= cfg_vals[r];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      r = r.next();
    end while (r != r.first());
    cfg_valid  <= 1'b0;
    cur_target = cfg_vals[apid_pkg::REG_ALT_SETPOINT];
    settings++;
  endtask

  function automatic logic [31:0] near_zero(input int unsigned mag);
    return 32'($urandom_range(0, 2 * mag)) - 32'(mag);
  endfunction

  function automatic logic [31:0] pick_reg_value(input apid_pkg::cfg_reg_t r,
                                                 input cfg_style_t style);
    logic [31:0] v;
    case (style)
      CFG_MAX: v = apid_pkg::S32_MAX;
      CFG_MIN: v = apid_pkg::S32_MIN;   // limit keeps only 31 bits, so this gives a zero limit
      CFG_MODERATE: begin
        case (r)
          apid_pkg::REG_ALT_SETPOINT: v = near_zero(8 << FB);
          apid_pkg::REG_PROPORTIONAL: v = near_zero(4 << FB);
          apid_pkg::REG_INTEGRAL:     v = near_zero(1 << (FB - 1));
          apid_pkg::REG_DERIVATIVE:   v = near_zero(4 << FB);
          apid_pkg::REG_ROLL_GAIN:    v = near_zero(2 << FB);
          apid_pkg::REG_PITCH_GAIN:   v = near_zero(2 << FB);
          apid_pkg::REG_HOVER_THRUST: v = $urandom_range(0, 2 << FB);
          default: v = $urandom_range(1 << FB, 8 << FB) | ($urandom_range(1) << 31);
        endcase
      end
      default: begin
        case ($urandom_range(4))
          0: v = $urandom;
          1: v = apid_pkg::S32_MAX;
          2: v = apid_pkg::S32_MIN;
          3: v = '0;
          default: v = pick_reg_value(r, CFG_MODERATE);
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic fill_config(input cfg_style_t style);
    apid_pkg::cfg_reg_t r;
    r = r.first();
    do begin
      cfg_vals[r] = pick_reg_value(r, style);
      r = r.next();
    end while (r != r.first());
  endtask

  function automatic logic [31:0] edge_value();
    logic [31:0] v;
    case ($urandom_range(9))
      0: v = apid_pkg::S32_MIN;
      1: v = apid_pkg::S32_MAX;
      2: v = '0;
      3: v = 32'sd1;
      4: v = -32'sd1;
      5: v = ONE;
      6: v = -ONE;
      7: v = ONE + 1;
      8: v = -ONE - 1;
      default: v = ONE - 1;
    endcase
    return v;
  endfunction

  // Mostly values around the +-1.0 angle clamp, with full-range and corner values
  function automatic logic [31:0] rand_field();
    logic [31:0] v;
    case ($urandom_range(9))
      0, 1, 2: v = $urandom;
      3:       v = edge_value();
      default: v = near_zero(2 << FB);
    endcase
    return v;
  endfunction

  function automatic apid_pkg::sample_t mk_sample(input logic [31:0] alt,
                                                  input logic [31:0] ra,
                                                  input logic [31:0] pa,
                                                  input logic [31:0] rr,
                                                  input logic [31:0] pr);
    apid_pkg::sample_t s;
    s.altitude    = alt;
    s.roll_angle  = ra;
    s.pitch_angle = pa;
    s.roll_rate   = rr;
    s.pitch_rate  = pr;
    return s;
  endfunction

  function automatic apid_pkg::sample_t random_sample();
    logic [31:0] alt;
    // a third of the altitudes sit close to the setpoint
    if ($urandom_range(2) == 0) alt = cur_target + near_zero(4 << FB);
    else alt = rand_field();
    return mk_sample(alt, rand_field(), rand_field(), rand_field(), rand_field());
  endfunction

  initial begin
    cfg_style_t style;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    set_flow(FLOW_FREE);

    // Reset settings: zero limit forces motors to zero; error saturates upward, error difference downward
    send_sample(mk_sample('0, ONE, -ONE, '0, '0));
    send_sample(mk_sample(apid_pkg::S32_MIN, apid_pkg::S32_MAX, apid_pkg::S32_MIN,
                          apid_pkg::S32_MAX, apid_pkg::S32_MIN));
    send_sample(mk_sample(apid_pkg::S32_MAX, ONE + 1, -ONE - 1, -32'sd1, 32'sd1));
    settle();

    // Plain gains: angle clamp boundaries and extreme rates into the motor clamp
    cfg_vals[apid_pkg::REG_ALT_SETPOINT] = 2 * ONE;
    cfg_vals[apid_pkg::REG_PROPORTIONAL] = ONE;
    cfg_vals[apid_pkg::REG_INTEGRAL]     = ONE / 2;
    cfg_vals[apid_pkg::REG_DERIVATIVE]   = ONE / 4;
    cfg_vals[apid_pkg::REG_ROLL_GAIN]    = ONE;
    cfg_vals[apid_pkg::REG_PITCH_GAIN]   = -ONE;
    cfg_vals[apid_pkg::REG_HOVER_THRUST] = ONE / 2;
    cfg_vals[apid_pkg::REG_MOTOR_LIMIT]  = 4 * ONE;
    load_config();
    send_sample(mk_sample(ONE, ONE, -ONE, '0, '0));
    send_sample(mk_sample(ONE, ONE + 1, -ONE - 1, '0, '0));
    send_sample(mk_sample(ONE, ONE - 1, -ONE + 1, ONE / 2, -ONE / 2));
    send_sample(mk_sample('0, apid_pkg::S32_MAX, apid_pkg::S32_MIN, '0, '0));
    send_sample(mk_sample('0, '0, '0, apid_pkg::S32_MAX, apid_pkg::S32_MIN));
    send_sample(mk_sample('0, '0, '0, apid_pkg::S32_MIN, apid_pkg::S32_MAX));
    send_sample(mk_sample(-32'sd1, -32'sd1, 32'sd1, 32'sd1, -32'sd1));
    send_sample(mk_sample(2 * ONE, '0, '0, '0, '0));
    settle();

    // Largest registers: integral runs into positive saturation
    fill_config(CFG_MAX);
    load_config();
    send_sample(mk_sample(apid_pkg::S32_MIN, apid_pkg::S32_MAX, apid_pkg::S32_MIN,
                          apid_pkg::S32_MAX, apid_pkg::S32_MAX));
    send_sample(mk_sample(apid_pkg::S32_MIN, apid_pkg::S32_MIN, apid_pkg::S32_MAX,
                          apid_pkg::S32_MIN, apid_pkg::S32_MIN));
    send_sample(mk_sample(apid_pkg::S32_MIN, ONE, ONE, '0, '0));
    send_sample(mk_sample(apid_pkg::S32_MAX, -ONE, -ONE, '0, '0));
    settle();

    // Smallest registers: negative saturation, zero limit
    fill_config(CFG_MIN);
    load_config();
    send_sample(mk_sample(apid_pkg::S32_MAX, apid_pkg::S32_MAX, apid_pkg::S32_MAX,
                          apid_pkg::S32_MAX, apid_pkg::S32_MAX));
    send_sample(mk_sample(apid_pkg::S32_MAX, apid_pkg::S32_MIN, apid_pkg::S32_MIN,
                          apid_pkg::S32_MIN, apid_pkg::S32_MIN));
    send_sample(mk_sample(apid_pkg::S32_MAX, '0, '0, '0, '0));
    settle();

    // Random phases, each with fresh registers and its own flow-control mode
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) style = CFG_MAX;
      else if (p == 1) style = CFG_MIN;
      else if (p % 2 == 0) style = CFG_MODERATE;
      else style = CFG_MIXED;
      set_flow(FLOW_FREE);
      fill_config(style);
      load_config();
      set_flow(flow_mode_t'(p % 4));
      repeat (PHASE_ITEMS) send_sample(random_sample());
      settle();
    end

    set_flow(FLOW_FREE);
    repeat (12) @(posedge clk);
    $display("Sent %0d samples and checked %0d results over %0d register settings,",
             sent, checked, settings);
    $display("with free flow, sender gaps, receiver stalls and both together.");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
